// ----- rtl/zctd_pkg.sv -----
// Shared types, codes and character tables for the text decoder.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package zctd_pkg;

  // Result kinds on the output stream
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_NL     = 2'd2;
  localparam logic [1:0] KIND_ABBREV = 2'd3;

  // Alphabet selectors
  localparam logic [1:0] SHIFT_A0 = 2'd0;
  localparam logic [1:0] SHIFT_A1 = 2'd1;
  localparam logic [1:0] SHIFT_A2 = 2'd2;

  // Literal escape phases
  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_HIGH = 2'd1;
  localparam logic [1:0] PHASE_LOW  = 2'd2;

  // Code values with a fixed meaning
  localparam logic [4:0] CODE_SPACE     = 5'd0;
  localparam logic [4:0] CODE_FIRST_CHR = 5'd6;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;

  localparam logic [3:0] VERSION_RESET = 4'd3;

  // One code slot passed from front to back
  typedef struct packed {
    logic [4:0] code;
    logic       done;   // word carries the end-of-string mark
    logic       last;   // third code of the word
  } zctd_code_t;

  // Remainder by three for small sums
  function automatic logic [1:0] mod3(input logic [2:0] v);
    logic [1:0] r;
    case (v)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd2;
      3'd6:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // Punctuation alphabet of version 1
  function automatic logic [7:0] punct_v1(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:  c = 8'd32;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5,
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10: c = 8'd47 + {3'd0, idx};
      5'd11: c = 8'd46;
      5'd12: c = 8'd44;
      5'd13: c = 8'd33;
      5'd14: c = 8'd63;
      5'd15: c = 8'd95;
      5'd16: c = 8'd35;
      5'd17: c = 8'd39;
      5'd18: c = 8'd34;
      5'd19: c = 8'd47;
      5'd20: c = 8'd92;
      5'd21: c = 8'd60;
      5'd22: c = 8'd45;
      5'd23: c = 8'd58;
      5'd24: c = 8'd40;
      5'd25: c = 8'd41;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Punctuation alphabet of version 2 and later
  function automatic logic [7:0] punct_v2(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:  c = 8'd32;
      5'd1:  c = 8'd10;
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
      5'd7, 5'd8, 5'd9, 5'd10, 5'd11: c = 8'd46 + {3'd0, idx};
      5'd12: c = 8'd46;
      5'd13: c = 8'd44;
      5'd14: c = 8'd33;
      5'd15: c = 8'd63;
      5'd16: c = 8'd95;
      5'd17: c = 8'd35;
      5'd18: c = 8'd39;
      5'd19: c = 8'd34;
      5'd20: c = 8'd47;
      5'd21: c = 8'd92;
      5'd22: c = 8'd45;
      5'd23: c = 8'd58;
      5'd24: c = 8'd40;
      5'd25: c = 8'd41;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Character for an alphabet index
  function automatic logic [7:0] alpha_char(input logic [1:0] shift,
                                            input logic [4:0] idx,
                                            input logic       ver1);
    logic [7:0] c;
    case (shift)
      SHIFT_A2: c = ver1 ? punct_v1(idx) : punct_v2(idx);
      SHIFT_A1: c = 8'd65 + {3'd0, idx};
      default:  c = 8'd97 + {3'd0, idx};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/zctd_front.sv -----
// Front end: takes packed words and issues their three codes in order.
// Depends on zctd_pkg for the code slot type.
`timescale 1ns / 1ps

module zctd_front import zctd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       word_valid_i,
  output logic       word_ready_o,
  input  logic [15:0] word_i,
  output logic       push_o,
  input  logic       push_ready_i,
  output zctd_code_t push_data_o
);

  logic [15:0] word_q, word_d;
  logic        valid_q, valid_d;
  logic [1:0]  idx_q, idx_d;
  logic        push_ok;
  logic        take;

  assign push_o      = valid_q;
  assign push_ok     = valid_q && push_ready_i;
  assign word_ready_o = !valid_q || (idx_q == 2'd2 && push_ok);
  assign take        = word_valid_i && word_ready_o;

  // Pick the code of the current slot, high bits first
  always_comb begin
    case (idx_q)
      2'd0:    push_data_o.code = word_q[14:10];
      2'd1:    push_data_o.code = word_q[9:5];
      default: push_data_o.code = word_q[4:0];
    endcase
    push_data_o.done = word_q[15];
    push_data_o.last = (idx_q == 2'd2);
  end

  // Advance the slot counter, load the next word after the third slot
  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (push_ok) begin
      if (idx_q == 2'd2) begin
        valid_d = 1'b0;
        idx_d   = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (take) begin
      word_d  = word_i;
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ----- rtl/zctd_fifo.sv -----
// Short queue of code slots between the front and back ends.
// Depends on zctd_pkg for the slot type.
`timescale 1ns / 1ps

module zctd_fifo import zctd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       push_ready_o,
  input  zctd_code_t push_data_i,
  output logic       head_valid_o,
  input  logic       pop_i,
  output zctd_code_t head_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  zctd_code_t    mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          wr_en, rd_en;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign wr_en        = push_i && push_ready_o;
  assign rd_en        = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  // Store the incoming slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Move the pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/zctd_back.sv -----
// Back end: decodes one code slot a cycle, while beats are taken, against
// the alphabet state and drives the registered result beat. Depends on zctd_pkg.
`timescale 1ns / 1ps

module zctd_back import zctd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       head_valid_i,
  input  zctd_code_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_char_o,
  output logic [6:0] out_abbrev_o,
  output logic       out_done_o,
  output logic       out_last_o
);

  logic [3:0] ver_q;
  logic [1:0] shift_now_q, shift_now_d;
  logic [1:0] shift_lock_q, shift_lock_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] high_q, high_d;
  logic       pend_q, pend_d;
  logic [1:0] bank_q, bank_d;

  logic       out_valid_q;
  logic [1:0] kind_q, kind_d;
  logic [7:0] char_q, char_d;
  logic [6:0] abbrev_q, abbrev_d;
  logic       done_q, last_q;

  logic       ver1, ver_lt3;
  logic [4:0] code;
  logic [4:0] idx;

  assign ver1    = (ver_q <= 4'd1);
  assign ver_lt3 = (ver_q < 4'd3);
  assign code    = head_i.code;
  assign idx     = code - CODE_FIRST_CHR;
  assign pop_o   = head_valid_i && (!out_valid_q || out_ready_i);

  // Decode the head slot
  always_comb begin
    kind_d       = KIND_NONE;
    char_d       = 8'd0;
    abbrev_d     = 7'd0;
    shift_now_d  = shift_now_q;
    shift_lock_d = shift_lock_q;
    phase_d      = phase_q;
    high_d       = high_q;
    pend_d       = pend_q;
    bank_d       = bank_q;
    if (pend_q) begin
      pend_d      = 1'b0;
      kind_d      = KIND_ABBREV;
      abbrev_d    = {bank_q, code};
      shift_now_d = shift_lock_q;
    end else if (phase_q == PHASE_HIGH) begin
      high_d  = code[2:0];
      phase_d = PHASE_LOW;
    end else if (phase_q != PHASE_NONE) begin
      phase_d = PHASE_NONE;
      kind_d  = KIND_CHAR;
      char_d  = {high_q, code};
    end else if (code >= CODE_FIRST_CHR) begin
      if (shift_now_q == SHIFT_A2 && idx == 5'd0) begin
        phase_d = PHASE_HIGH;
      end else if (shift_now_q == SHIFT_A2 && idx == 5'd1 && !ver1) begin
        kind_d = KIND_NL;
      end else begin
        kind_d = KIND_CHAR;
        char_d = alpha_char(shift_now_q, idx, ver1);
      end
      shift_now_d = shift_lock_q;
    end else if (code == CODE_SPACE) begin
      kind_d = KIND_CHAR;
      char_d = CHAR_SPACE;
    end else if (ver_lt3) begin
      if (code == 5'd1) begin
        if (ver1) begin
          kind_d = KIND_NL;
        end else begin
          pend_d = 1'b1;
          bank_d = 2'd0;
        end
      end else if (code < 5'd4) begin
        shift_now_d = mod3({1'b0, shift_lock_q} + code[2:0] + 3'd2);
      end else begin
        shift_lock_d = mod3({1'b0, shift_lock_q} + code[2:0]);
        shift_now_d  = shift_lock_d;
      end
    end else begin
      if (code < 5'd4) begin
        pend_d = 1'b1;
        bank_d = code[1:0] - 2'd1;
      end else begin
        shift_now_d  = code[1:0] - 2'd3;
        shift_lock_d = SHIFT_A0;
      end
    end
    // Drop all state once the final word has been worked off
    if (head_i.done && head_i.last) begin
      shift_now_d  = SHIFT_A0;
      shift_lock_d = SHIFT_A0;
      phase_d      = PHASE_NONE;
      high_d       = 3'd0;
      pend_d       = 1'b0;
      bank_d       = 2'd0;
    end
  end

  // Hold the version and the decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q        <= VERSION_RESET;
      shift_now_q  <= SHIFT_A0;
      shift_lock_q <= SHIFT_A0;
      phase_q      <= PHASE_NONE;
      high_q       <= 3'd0;
      pend_q       <= 1'b0;
      bank_q       <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ver_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        shift_now_q  <= shift_now_d;
        shift_lock_q <= shift_lock_d;
        phase_q      <= phase_d;
        high_q       <= high_d;
        pend_q       <= pend_d;
        bank_q       <= bank_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      char_q   <= char_d;
      abbrev_q <= abbrev_d;
      done_q   <= head_i.done;
      last_q   <= head_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = kind_q;
  assign out_char_o   = char_q;
  assign out_abbrev_o = abbrev_q;
  assign out_done_o   = done_q;
  assign out_last_o   = last_q;

endmodule

// ----- rtl/zchar_text_decoder.sv -----
// Top level of the packed text decoder: front end, slot queue, back end.
// Depends on zctd_pkg, zctd_front, zctd_fifo and zctd_back.
//
// Usage:
//   Slave stream: one packed text word per beat; bit 15 marks the final
//   word of a string, bits 14..10, 9..5 and 4..0 hold the three codes.
//   Master stream: three result beats per word, one per code, in order.
//   tuser gives the result kind (none, character, newline, abbreviation
//   request) and the end-of-string flag; tlast marks the third beat.
//   The caller fetches abbreviation text and translates characters.
//   Configuration: cfg_we_i writes the machine version; the user must do so
//   only while idle, as the block does not enforce it.
// Timing: the back end decodes one code per cycle and the single result
//   channel moves one beat per cycle, while beats are taken. Words are taken
//   back to back while results drain; a word passes the front-end word register,
//   the slot queue and the result register before its first beat is valid.
// Reset: clears the alphabet, literal and abbreviation state, empties
//   the queue and sets the version to 3.
// Stall: the result register holds its beat; the queue fills and then
//   the input stream is held off until beats are taken again.
`timescale 1ns / 1ps

module zchar_text_decoder import zctd_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] text_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] char_value, [14:8] abbrev_index, [15] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] result_kind, [2] string_done
  output logic        m_axis_tlast    // last_of_word
);

  logic       push;
  logic       push_ready;
  zctd_code_t push_data;
  logic       head_valid;
  logic       pop;
  zctd_code_t head;
  logic [1:0] kind;
  logic [7:0] char_value;
  logic [6:0] abbrev_index;
  logic       string_done;

  // Split words into code slots
  zctd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (s_axis_tvalid),
    .word_ready_o (s_axis_tready),
    .word_i       (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the two ends
  zctd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  // Decode slots into result beats
  zctd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (kind),
    .out_char_o   (char_value),
    .out_abbrev_o (abbrev_index),
    .out_done_o   (string_done),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, abbrev_index, char_value};
  assign m_axis_tuser = {string_done, kind};

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for zchar_text_decoder: directed table, then random strings.
// Depends on rtl/zctd_pkg.sv and the decoder RTL; results checked against a local model.
`timescale 1ns / 1ps

module testbench;
  import zctd_pkg::*;

  // Codes 1 to 5 change meaning with the machine version
  localparam logic [4:0] ZC_ABBREV_LO = 5'd1;
  localparam logic [4:0] ZC_ABBREV_HI = 5'd3;
  localparam logic [4:0] ZC_SHIFT_A1  = 5'd4;
  localparam logic [4:0] ZC_SHIFT_A2  = 5'd5;
  localparam logic [4:0] ZC_TOP       = 5'd31;

  localparam bit [8*26-1:0] PUNCT_OLD = " 0123456789.,!?_#'\"/\\<-:()";
  localparam bit [8*26-1:0] PUNCT_NEW = " \n0123456789.,!?_#'\"/\\-:()";

  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 22;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] chr;
    logic [6:0] abbrev;
    logic       str_end;
    logic       word_last;
  } zresult_t;

  // One row of the directed table: a version write or a text word,
  // with the kind, character and abbreviation of each slot typed in where obvious
  typedef struct packed {
    logic             is_cfg;
    logic [15:0]      value;
    logic             typed;
    logic [2:0][16:0] slots;
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Local copy of the decoder state
  logic [3:0] mdl_version;
  logic [1:0] mdl_shift;
  logic [1:0] mdl_lock;
  logic [1:0] mdl_phase;
  logic [2:0] mdl_high;
  logic       mdl_pend;
  logic [1:0] mdl_bank;

  zresult_t  due_results[$];
  stim_row_t directed_rows[$];

  int  mismatches   = 0;
  int  words_sent   = 0;
  int  beats_seen   = 0;
  int  quiet_cycles = 0;
  int  stall_left   = 0;
  int  versions_run = 0;
  bit  calm         = 1'b0;

  zchar_text_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Clear the alphabet, literal and abbreviation state
  function automatic void clear_text_state();
    mdl_shift = SHIFT_A0;
    mdl_lock  = SHIFT_A0;
    mdl_phase = PHASE_NONE;
    mdl_high  = 3'd0;
    mdl_pend  = 1'b0;
    mdl_bank  = 2'd0;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [1:0] sel, input logic [4:0] idx,
                                               input bit old_rules);
    if (sel == SHIFT_A2) begin
      return old_rules ? PUNCT_OLD[8*(25-idx) +: 8] : PUNCT_NEW[8*(25-idx) +: 8];
    end else if (sel == SHIFT_A1) begin
      return 8'd65 + {3'd0, idx};
    end
    return 8'd97 + {3'd0, idx};
  endfunction

  // Decode one code against the local state
  function automatic zresult_t decode_code(input logic [4:0] code);
    zresult_t r;
    int       ver;
    logic [4:0] idx;
    ver = (mdl_version == 4'd0) ? 1 : int'(mdl_version);
    r = '0;
    r.kind = KIND_NONE;
    idx = code - CODE_FIRST_CHR;
    if (mdl_pend) begin
      mdl_pend  = 1'b0;
      r.kind    = KIND_ABBREV;
      r.abbrev  = {mdl_bank, code};
      mdl_shift = mdl_lock;
    end else if (mdl_phase == PHASE_HIGH) begin
      mdl_high  = code[2:0];
      mdl_phase = PHASE_LOW;
    end else if (mdl_phase != PHASE_NONE) begin
      mdl_phase = PHASE_NONE;
      r.kind    = KIND_CHAR;
      r.chr     = {mdl_high, code};
    end else if (code >= CODE_FIRST_CHR) begin
      if (mdl_shift == SHIFT_A2 && idx == 5'd0) begin
        mdl_phase = PHASE_HIGH;
      end else if (mdl_shift == SHIFT_A2 && idx == 5'd1 && ver > 1) begin
        r.kind = KIND_NL;
      end else begin
        r.kind = KIND_CHAR;
        r.chr  = alphabet_char(mdl_shift, idx, ver == 1);
      end
      mdl_shift = mdl_lock;
    end else if (code == CODE_SPACE) begin
      r.kind = KIND_CHAR;
      r.chr  = CHAR_SPACE;
    end else if (ver < 3) begin
      // older rules: shifts are relative to the lock
      if (code == ZC_ABBREV_LO) begin
        if (ver == 1) begin
          r.kind = KIND_NL;
        end else begin
          mdl_pend = 1'b1;
          mdl_bank = 2'd0;
        end
      end else if (code < ZC_SHIFT_A1) begin
        mdl_shift = 2'((int'(mdl_lock) + int'(code) + 2) % 3);
      end else begin
        mdl_lock  = 2'((int'(mdl_lock) + int'(code)) % 3);
        mdl_shift = mdl_lock;
      end
    end else if (code <= ZC_ABBREV_HI) begin
      mdl_pend = 1'b1;
      mdl_bank = 2'(code - ZC_ABBREV_LO);
    end else begin
      mdl_shift = 2'(code - ZC_ABBREV_HI);
      mdl_lock  = SHIFT_A0;
    end
    return r;
  endfunction

  // Queue the three results of an accepted word; typed slots override kind and payload
  function automatic void decode_word(input logic [15:0] w, input logic typed,
                                      input logic [2:0][16:0] slots);
    zresult_t r;
    for (int k = 0; k < 3; k++) begin
      r = decode_code(w[10-5*k +: 5]);
      if (typed) {r.kind, r.chr, r.abbrev} = slots[2-k];
      r.str_end   = w[15];
      r.word_last = (k == 2);
      due_results.push_back(r);
    end
    if (w[15]) clear_text_state();
  endfunction

  function automatic logic [15:0] zword(input logic fin, input logic [4:0] c0,
                                        input logic [4:0] c1, input logic [4:0] c2);
    return {fin, c0, c1, c2};
  endfunction

  function automatic logic [16:0] slot(input logic [1:0] kind, input logic [7:0] chr,
                                       input logic [6:0] abbrev);
    return {kind, chr, abbrev};
  endfunction

  function automatic void add_word(input logic [15:0] w);
    directed_rows.push_back({1'b0, w, 1'b0, 51'd0});
  endfunction

  function automatic void add_typed(input logic [15:0] w, input logic [16:0] s0,
                                    input logic [16:0] s1, input logic [16:0] s2);
    directed_rows.push_back({1'b0, w, 1'b1, s0, s1, s2});
  endfunction

  function automatic void add_version(input logic [3:0] v);
    directed_rows.push_back({1'b1, 12'd0, v, 1'b0, 51'd0});
  endfunction

  function automatic logic [4:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return 5'($urandom_range(0, 5));
      1:       return CODE_FIRST_CHR;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one word, with an optional gap first, and hold it until accepted
  task automatic send_word(input logic [15:0] w, input logic typed,
                           input logic [2:0][16:0] slots);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_word(w, typed, slots);
    words_sent++;
  endtask

  // Write the version once every result of earlier words has come out
  task automatic write_version(input logic [3:0] v);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mdl_version = v;
    versions_run++;
  endtask

  // Result side: stall in random bursts unless calm
  always @(posedge clk_i) begin
    if (!calm && stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && rst_ni && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_beat
    zresult_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (due_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %h", m_axis_tdata,
               m_axis_tuser);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("result_kind", want.kind, m_axis_tuser[1:0]);
        check_field("char_value", want.chr, m_axis_tdata[7:0]);
        check_field("abbrev_index", want.abbrev, m_axis_tdata[14:8]);
        check_field("tdata pad", 0, m_axis_tdata[15]);
        check_field("string_done", want.str_end, m_axis_tuser[2]);
        check_field("last_of_word", want.word_last, m_axis_tlast);
      end
    end
  end

  // Watchdog: end the run after too long without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat for %0d cycles, %0d results outstanding", quiet_cycles,
               due_results.size());
      $display("zchar_text_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    logic [3:0]  phase_versions [8];
    logic [15:0] w;
    int          len;
    int          n;
    stim_row_t   row;

    mdl_version = VERSION_RESET;
    clear_text_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset version first
    add_typed(16'h0000, slot(KIND_CHAR, 8'd32, 0), slot(KIND_CHAR, 8'd32, 0),
              slot(KIND_CHAR, 8'd32, 0));
    add_typed(16'h7fff, slot(KIND_CHAR, 8'd122, 0), slot(KIND_CHAR, 8'd122, 0),
              slot(KIND_CHAR, 8'd122, 0));
    add_typed(16'h8000, slot(KIND_CHAR, 8'd32, 0), slot(KIND_CHAR, 8'd32, 0),
              slot(KIND_CHAR, 8'd32, 0));
    add_typed(zword(0, ZC_SHIFT_A1, 6, 7), slot(KIND_NONE, 0, 0), slot(KIND_CHAR, 8'd65, 0),
              slot(KIND_CHAR, 8'd98, 0));
    add_typed(zword(0, ZC_SHIFT_A2, 7, ZC_SHIFT_A2), slot(KIND_NONE, 0, 0),
              slot(KIND_NL, 0, 0), slot(KIND_NONE, 0, 0));
    // literal escape: high part 3, low part 1
    add_typed(zword(0, CODE_FIRST_CHR, 3, 1), slot(KIND_NONE, 0, 0), slot(KIND_NONE, 0, 0),
              slot(KIND_CHAR, 8'd97, 0));
    add_typed(zword(0, ZC_ABBREV_LO, ZC_TOP, ZC_ABBREV_HI), slot(KIND_NONE, 0, 0),
              slot(KIND_ABBREV, 0, 7'd31), slot(KIND_NONE, 0, 0));
    add_typed(zword(1, ZC_TOP, 0, 0), slot(KIND_ABBREV, 0, 7'd95), slot(KIND_CHAR, 8'd32, 0),
              slot(KIND_CHAR, 8'd32, 0));
    // end of string drops a half-built literal, then an abbreviation
    add_typed(zword(1, ZC_SHIFT_A2, CODE_FIRST_CHR, 2), slot(KIND_NONE, 0, 0),
              slot(KIND_NONE, 0, 0), slot(KIND_NONE, 0, 0));
    add_typed(16'h0000, slot(KIND_CHAR, 8'd32, 0), slot(KIND_CHAR, 8'd32, 0),
              slot(KIND_CHAR, 8'd32, 0));
    add_word(zword(1, 0, 0, ZC_ABBREV_HI - 5'd1));
    add_word(zword(0, ZC_SHIFT_A2, ZC_TOP, ZC_SHIFT_A2));
    add_typed(zword(1, CODE_FIRST_CHR, 0, 0), slot(KIND_NONE, 0, 0), slot(KIND_NONE, 0, 0),
              slot(KIND_CHAR, 8'd0, 0));
    // older rules: newline code, relative shifts, bank 0 only
    add_version(4'd1);
    add_word(zword(0, ZC_ABBREV_LO, ZC_SHIFT_A2, 7));
    add_word(zword(0, 2, CODE_FIRST_CHR, ZC_SHIFT_A1));
    add_word(zword(1, ZC_ABBREV_HI, ZC_TOP, ZC_ABBREV_LO));
    add_version(4'd2);
    add_word(zword(0, ZC_ABBREV_LO, 17, ZC_SHIFT_A2));
    add_word(zword(0, 7, CODE_FIRST_CHR, ZC_TOP));
    add_word(zword(1, ZC_TOP, ZC_SHIFT_A1, 0));
    add_version(4'd8);
    add_word(zword(0, ZC_SHIFT_A1, ZC_SHIFT_A2, CODE_FIRST_CHR));
    add_word(zword(1, 0, 9, 0));
    add_version(4'd0);
    add_word(zword(1, ZC_ABBREV_LO, ZC_ABBREV_HI, ZC_SHIFT_A1));
    add_version(4'd15);
    add_typed(zword(1, ZC_ABBREV_HI, ZC_TOP, 0), slot(KIND_NONE, 0, 0),
              slot(KIND_ABBREV, 0, 7'd95), slot(KIND_CHAR, 8'd32, 0));
    add_word(16'hffff);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        write_version(row.value[3:0]);
      end else begin
        send_word(row.value, row.typed, row.slots);
      end
    end

    // Random strings: one version per phase, the last phase with no idling
    phase_versions = '{4'd3, 4'd1, 4'd2, 4'd8, 4'd0, 4'd15,
                       4'($urandom_range(1, 8)), 4'($urandom_range(0, 15))};
    foreach (phase_versions[p]) begin
      write_version(phase_versions[p]);
      calm = (p == 7) || ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PHASE_WORDS) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len && n < PHASE_WORDS; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            w = 16'($urandom_range(0, 65535));
          end else begin
            w = zword(j == len - 1 || n == PHASE_WORDS - 1, pick_code(), pick_code(),
                      pick_code());
          end
          send_word(w, 1'b0, '0);
          n++;
        end
      end
    end

    // Drain, then watch for stray beats
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d text words under %0d version writes; checked %0d result beats.",
             words_sent, versions_run, beats_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("zchar_text_decoder regression: pass");
    end else begin
      $display("zchar_text_decoder regression: fail");
    end
    $finish;
  end

endmodule
